// ===== hw/rtl/gcs_pkg.sv =====
package gcs_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  localparam int unsigned COUNT_W = 32;

  typedef enum logic [3:0] {
    MODE_CODE     = 4'd0,
    MODE_SLASH    = 4'd1,
    MODE_LINE     = 4'd2,
    MODE_BLOCK    = 4'd3,
    MODE_BSTAR    = 4'd4,
    MODE_STR      = 4'd5,
    MODE_STR_ESC  = 4'd6,
    MODE_RAW      = 4'd7,
    MODE_RUNE     = 4'd8,
    MODE_RUNE_ESC = 4'd9
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic               has_byte;
    logic [7:0]         out_byte;
    logic               run_last;
    logic               stream_end;
    logic [COUNT_W-1:0] line_total;
  } out_word_t;

  // scanner state carried from one byte to the next
  typedef struct packed {
    mode_t              mode;
    logic               has_text;
    logic [COUNT_W-1:0] count;
  } scan_state_t;

  typedef struct packed {
    scan_state_t state_nxt;
    logic [1:0]  n_res;
    out_word_t   res0;
    out_word_t   res1;
  } step_out_t;

endpackage

// ===== hw/rtl/go_comment_stripper_line_count_core.sv =====
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | in_data  (gcs_pkg::in_word_t)
// output  | out_valid| out_stall | out_data (gcs_pkg::out_word_t)
//
// one byte is taken per cycle while in_stall is low; it is registered, then queued
// a byte giving two words (released slash) pushes both together; the output pops one at a time
// the byte register advances while the 4-word output queue holds at least two free slots
// reset (rst_n low, synchronous) empties the queue and returns the scanner to code mode
// out_stall backs up through the queue into in_stall without dropping a word
module go_comment_stripper_line_count_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gcs_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gcs_pkg::out_word_t  out_data
);

  logic                 in_vld_r;
  gcs_pkg::in_word_t    in_word_r;
  gcs_pkg::scan_state_t st_r;
  gcs_pkg::step_out_t   step;
  gcs_pkg::out_word_t   q_r [4];
  logic [1:0]           wr_ptr_r;
  logic [1:0]           rd_ptr_r;
  logic [2:0]           cnt_r;
  logic [2:0]           cnt_nxt;
  logic                 proc;
  logic                 pop;
  logic [1:0]           n_push;

  gcs_step u_step (
    .st   (st_r),
    .word (in_word_r),
    .res  (step)
  );

  assign proc      = in_vld_r && cnt_r <= 3'd2;
  assign in_stall  = in_vld_r && !proc;
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign n_push    = proc ? step.n_res : 2'd0;
  assign cnt_nxt   = cnt_r + {1'b0, n_push} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r          <= 1'b0;
      st_r.mode         <= gcs_pkg::MODE_CODE;
      st_r.has_text     <= 1'b0;
      st_r.count        <= '0;
      wr_ptr_r          <= 2'd0;
      rd_ptr_r          <= 2'd0;
      cnt_r             <= 3'd0;
    end else begin
      if (!in_stall) begin
        in_vld_r  <= in_valid;
        in_word_r <= in_data;
      end
      if (proc) st_r <= step.state_nxt;
      wr_ptr_r <= wr_ptr_r + n_push;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_r[wr_ptr_r] <= step.res0;
    if (n_push == 2'd2) q_r[wr_ptr_r + 2'd1] <= step.res1;
  end

endmodule

// ===== hw/rtl/gcs_step.sv =====
module gcs_step (
  input  gcs_pkg::scan_state_t st,
  input  gcs_pkg::in_word_t    word,
  output gcs_pkg::step_out_t   res
);

  logic                        k0_v;
  logic                        k1_v;
  logic [7:0]                  k0;
  logic [7:0]                  k1;
  logic [7:0]                  c;
  logic                        last;
  gcs_pkg::mode_t              mode_n;
  logic                        ht_a;
  logic                        ht_b;
  logic                        bump_a;
  logic                        bump_b;
  logic                        bump_f;
  logic                        ht_end;
  logic [gcs_pkg::COUNT_W-1:0] count_n;
  logic [1:0]                  n;

  function automatic gcs_pkg::mode_t code_mode(input logic [7:0] ch);
    gcs_pkg::mode_t m;
    m = gcs_pkg::MODE_CODE;
    if (ch == gcs_pkg::CH_DQUOTE) m = gcs_pkg::MODE_STR;
    else if (ch == gcs_pkg::CH_BQUOTE) m = gcs_pkg::MODE_RAW;
    else if (ch == gcs_pkg::CH_SQUOTE) m = gcs_pkg::MODE_RUNE;
    return m;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == gcs_pkg::CH_SPACE || ch == gcs_pkg::CH_TAB || ch == gcs_pkg::CH_CR;
  endfunction

  assign c    = word.in_byte;
  assign last = word.is_final;

  always_comb begin
    k0_v   = 1'b0;
    k1_v   = 1'b0;
    k0     = c;
    k1     = c;
    mode_n = st.mode;
    unique case (st.mode)
      gcs_pkg::MODE_SLASH: begin
        if (c == gcs_pkg::CH_SLASH) begin
          mode_n = gcs_pkg::MODE_LINE;
        end else if (c == gcs_pkg::CH_STAR) begin
          mode_n = gcs_pkg::MODE_BLOCK;
        end else begin
          k0_v   = 1'b1;
          k0     = gcs_pkg::CH_SLASH;
          k1_v   = 1'b1;
          mode_n = code_mode(c);
        end
      end
      gcs_pkg::MODE_LINE: begin
        if (c == gcs_pkg::CH_NL) begin
          k0_v   = 1'b1;
          mode_n = gcs_pkg::MODE_CODE;
        end
      end
      gcs_pkg::MODE_BLOCK, gcs_pkg::MODE_BSTAR: begin
        if (st.mode == gcs_pkg::MODE_BSTAR && c == gcs_pkg::CH_SLASH) begin
          mode_n = gcs_pkg::MODE_CODE;
        end else if (c == gcs_pkg::CH_STAR) begin
          mode_n = gcs_pkg::MODE_BSTAR;
        end else begin
          mode_n = gcs_pkg::MODE_BLOCK;
          k0_v   = (c == gcs_pkg::CH_NL);
        end
      end
      gcs_pkg::MODE_STR: begin
        k0_v = 1'b1;
        if (c == gcs_pkg::CH_BSLASH) mode_n = gcs_pkg::MODE_STR_ESC;
        else if (c == gcs_pkg::CH_DQUOTE) mode_n = gcs_pkg::MODE_CODE;
      end
      gcs_pkg::MODE_RUNE: begin
        k0_v = 1'b1;
        if (c == gcs_pkg::CH_BSLASH) mode_n = gcs_pkg::MODE_RUNE_ESC;
        else if (c == gcs_pkg::CH_SQUOTE) mode_n = gcs_pkg::MODE_CODE;
      end
      gcs_pkg::MODE_STR_ESC: begin
        k0_v   = 1'b1;
        mode_n = gcs_pkg::MODE_STR;
      end
      gcs_pkg::MODE_RUNE_ESC: begin
        k0_v   = 1'b1;
        mode_n = gcs_pkg::MODE_RUNE;
      end
      gcs_pkg::MODE_RAW: begin
        k0_v = 1'b1;
        if (c == gcs_pkg::CH_BQUOTE) mode_n = gcs_pkg::MODE_CODE;
      end
      default: begin
        if (c == gcs_pkg::CH_SLASH) begin
          if (last) k0_v = 1'b1;
          else mode_n = gcs_pkg::MODE_SLASH;
        end else begin
          k0_v   = 1'b1;
          mode_n = code_mode(c);
        end
      end
    endcase
  end

  // at most one line closes per byte, so a single saturating increment covers it
  always_comb begin
    bump_a = k0_v && k0 == gcs_pkg::CH_NL && st.has_text;
    if (!k0_v) ht_a = st.has_text;
    else if (k0 == gcs_pkg::CH_NL) ht_a = 1'b0;
    else ht_a = st.has_text | ~is_blank(k0);
    bump_b = k1_v && k1 == gcs_pkg::CH_NL && ht_a;
    if (!k1_v) ht_b = ht_a;
    else if (k1 == gcs_pkg::CH_NL) ht_b = 1'b0;
    else ht_b = ht_a | ~is_blank(k1);
    bump_f = last && ht_b;
    ht_end = ht_b;
    if ((bump_a || bump_b || bump_f) && st.count != '1) count_n = st.count + 1'b1;
    else count_n = st.count;
  end

  always_comb begin
    n = {1'b0, k0_v} + {1'b0, k1_v};
    if (last && n == 2'd0) n = 2'd1;

    res.n_res               = n;
    res.res0.has_byte       = k0_v;
    res.res0.out_byte       = k0_v ? k0 : 8'd0;
    res.res0.run_last       = (n == 2'd1);
    res.res0.stream_end     = last && n == 2'd1;
    res.res0.line_total     = (last && n == 2'd1) ? count_n : '0;
    res.res1.has_byte       = k1_v;
    res.res1.out_byte       = k1_v ? k1 : 8'd0;
    res.res1.run_last       = 1'b1;
    res.res1.stream_end     = last;
    res.res1.line_total     = last ? count_n : '0;

    if (last) begin
      res.state_nxt.mode     = gcs_pkg::MODE_CODE;
      res.state_nxt.has_text = 1'b0;
      res.state_nxt.count    = '0;
    end else begin
      res.state_nxt.mode     = mode_n;
      res.state_nxt.has_text = ht_end;
      res.state_nxt.count    = count_n;
    end
  end

endmodule

// ===== hw/rtl/gcs_checker.sv =====
module gcs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input gcs_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input gcs_pkg::out_word_t out_data
);

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word changed under stall");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.run_last)
    else $error("stream end without run_last");

  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |-> out_data.stream_end && out_data.out_byte == 8'd0)
    else $error("empty word outside stream end");

  a_total_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stream_end |-> out_data.line_total == '0)
    else $error("line total outside stream end");

endmodule

bind go_comment_stripper_line_count_core gcs_checker u_gcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import gcs_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  in_word_t  src_q[$];
  out_word_t stripped_q[$];
  logic [7:0] file_buf[$];

  int send_idle_pct = 23;
  int recv_idle_pct = 60;
  int n_in = 0;
  int n_out = 0;
  int n_files = 0;
  int n_fail = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // predictor state
  mode_t       scan_md = MODE_CODE;
  logic        text_seen = 1'b0;
  logic [31:0] nonblank_lines = '0;
  logic [7:0]  kept_b[2];
  int          nk;

  go_comment_stripper_line_count_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  task automatic keep_char(input logic [7:0] c);
    if (nk < 2) begin
      kept_b[nk] = c;
      nk++;
    end
    if (c == CH_NL) begin
      if (text_seen && nonblank_lines != 32'hffff_ffff) nonblank_lines++;
      text_seen = 1'b0;
    end else if (c != CH_SPACE && c != CH_TAB && c != CH_CR) begin
      text_seen = 1'b1;
    end
  endtask

  task automatic code_char(input logic [7:0] c, input logic fin);
    if (c == CH_SLASH) begin
      if (fin) keep_char(c);
      else scan_md = MODE_SLASH;
    end else begin
      if (c == CH_DQUOTE) scan_md = MODE_STR;
      else if (c == CH_BQUOTE) scan_md = MODE_RAW;
      else if (c == CH_SQUOTE) scan_md = MODE_RUNE;
      keep_char(c);
    end
  endtask

  task automatic strip_byte(input in_word_t w);
    logic [7:0]  c;
    logic        fin;
    int          n;
    logic [31:0] total;
    out_word_t   o;
    c = w.in_byte;
    fin = w.is_final;
    nk = 0;
    total = '0;
    case (scan_md)
      MODE_SLASH: begin
        if (c == CH_SLASH) scan_md = MODE_LINE;
        else if (c == CH_STAR) scan_md = MODE_BLOCK;
        else begin
          scan_md = MODE_CODE;
          keep_char(CH_SLASH);
          code_char(c, fin);
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          keep_char(c);
          scan_md = MODE_CODE;
        end
      end
      MODE_BLOCK, MODE_BSTAR: begin
        if (scan_md == MODE_BSTAR && c == CH_SLASH) scan_md = MODE_CODE;
        else if (c == CH_STAR) scan_md = MODE_BSTAR;
        else begin
          scan_md = MODE_BLOCK;
          if (c == CH_NL) keep_char(c);
        end
      end
      MODE_STR, MODE_RUNE: begin
        keep_char(c);
        if (c == CH_BSLASH) begin
          if (scan_md == MODE_STR) scan_md = MODE_STR_ESC;
          else scan_md = MODE_RUNE_ESC;
        end else if ((scan_md == MODE_STR && c == CH_DQUOTE) ||
                     (scan_md == MODE_RUNE && c == CH_SQUOTE)) begin
          scan_md = MODE_CODE;
        end
      end
      MODE_STR_ESC: begin
        keep_char(c);
        scan_md = MODE_STR;
      end
      MODE_RUNE_ESC: begin
        keep_char(c);
        scan_md = MODE_RUNE;
      end
      MODE_RAW: begin
        keep_char(c);
        if (c == CH_BQUOTE) scan_md = MODE_CODE;
      end
      default: begin
        scan_md = MODE_CODE;
        code_char(c, fin);
      end
    endcase
    n = nk;
    if (fin) begin
      if (text_seen && nonblank_lines != 32'hffff_ffff) nonblank_lines++;
      total = nonblank_lines;
      if (n == 0) n = 1;
    end
    for (int k = 0; k < n; k++) begin
      o = '0;
      o.has_byte = (k < nk);
      o.out_byte = (k < nk) ? kept_b[k] : 8'h00;
      o.run_last = (k == n - 1);
      o.stream_end = (k == n - 1) && fin;
      o.line_total = o.stream_end ? total : '0;
      stripped_q.push_back(o);
    end
    if (fin) begin
      scan_md = MODE_CODE;
      text_seen = 1'b0;
      nonblank_lines = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
      n_fail++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        strip_byte(in_data);
        void'(src_q.pop_front());
        n_in++;
      end
      if (!in_valid || !in_stall) begin
        if (src_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= src_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (stripped_q.size() == 0) begin
          $error("unexpected word: has_byte %0b out_byte %0h", out_data.has_byte,
                 out_data.out_byte);
          n_fail++;
        end else begin
          e = stripped_q.pop_front();
          check_field("has_byte", e.has_byte, out_data.has_byte);
          check_field("out_byte", e.out_byte, out_data.out_byte);
          check_field("run_last", e.run_last, out_data.run_last);
          check_field("stream_end", e.stream_end, out_data.stream_end);
          check_field("line_total", e.line_total, out_data.line_total);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_out >= 150) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** go_comment_stripper_line_count_core: FAILED **");
      $finish;
    end
  end

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: return 8'h61 + 8'($urandom_range(0, 25));
      5: return CH_SPACE;
      6: return CH_STAR;
      7: return CH_NL;
      8: return CH_BSLASH;
      9: begin
        case ($urandom_range(0, 2))
          0: return CH_DQUOTE;
          1: return CH_BQUOTE;
          default: return CH_SQUOTE;
        endcase
      end
      10: return CH_SLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_body(input int n);
    for (int i = 0; i < n; i++) file_buf.push_back(text_char());
  endtask

  task automatic push_file();
    in_word_t w;
    for (int i = 0; i < file_buf.size(); i++) begin
      w.in_byte = file_buf[i];
      w.is_final = (i == file_buf.size() - 1);
      src_q.push_back(w);
    end
    n_files++;
    file_buf.delete();
  endtask

  task automatic gen_file();
    int target;
    target = $urandom_range(1, 60);
    file_buf.delete();
    while (file_buf.size() < target) begin
      case ($urandom_range(0, 9))
        0: begin
          add_str("//");
          add_body($urandom_range(0, 8));
          file_buf.push_back(CH_NL);
        end
        1: begin
          add_str("/*");
          add_body($urandom_range(0, 10));
          if ($urandom_range(0, 1)) add_str("**");
          add_str("*/");
        end
        2: begin
          file_buf.push_back(CH_DQUOTE);
          add_body($urandom_range(0, 8));
          file_buf.push_back(CH_DQUOTE);
        end
        3: begin
          file_buf.push_back(CH_SQUOTE);
          if ($urandom_range(0, 1)) file_buf.push_back(CH_BSLASH);
          file_buf.push_back(text_char());
          file_buf.push_back(CH_SQUOTE);
        end
        4: begin
          file_buf.push_back(CH_BQUOTE);
          add_body($urandom_range(0, 8));
          file_buf.push_back(CH_BQUOTE);
        end
        5: begin
          repeat ($urandom_range(1, 6)) file_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
        end
        6: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0: file_buf.push_back(CH_SPACE);
              1: file_buf.push_back(CH_TAB);
              2: file_buf.push_back(CH_CR);
              default: file_buf.push_back(CH_NL);
            endcase
          end
        end
        7: begin
          file_buf.push_back(CH_SLASH);
          file_buf.push_back(text_char());
        end
        8: begin
          repeat ($urandom_range(1, 4)) file_buf.push_back(8'($urandom_range(0, 255)));
        end
        default: file_buf.push_back(CH_NL);
      endcase
    end
  endtask

  task automatic run_random(input int n_bytes);
    int made;
    made = 0;
    while (made < n_bytes) begin
      gen_file();
      made += file_buf.size();
      push_file();
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (src_q.size() != 0 || stripped_q.size() != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // block comment with slash-star-slash, newline kept, star run closing on final byte
    add_str("/*/\n**/");
    push_file();
    // escaped string, escaped rune, raw string, slash as final byte
    add_str("\"\\\"\"'\\''`/`/");
    push_file();
    // top-bit byte followed by blanks on one line, held slash released by final zero byte
    file_buf.push_back(8'hff);
    add_str(" \t\r\n/");
    file_buf.push_back(8'h00);
    push_file();
    // backslash as final byte inside a string
    add_str("\"\\");
    push_file();
    wait_drained();

    @(negedge clk);
    run_random(420);
    wait_drained();

    @(negedge clk);
    send_idle_pct = 60;
    recv_idle_pct = 23;
    run_random(420);
    wait_drained();

    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(420);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (stripped_q.size() != 0) begin
      $error("%0d expected words never arrived", stripped_q.size());
      n_fail++;
    end
    $display("stripped %0d bytes over %0d files, %0d words checked", n_in, n_files, n_out);
    $display("included a long output hold, drained pauses and three idle mixes");
    if (n_fail == 0) begin
      $display("** go_comment_stripper_line_count_core: PASSED **");
    end else begin
      $display("** go_comment_stripper_line_count_core: FAILED **");
    end
    $finish;
  end

endmodule
